// File: hdl/ip_address_text_validator_defines.svh
// Assertion macros used by the validator top level.
`ifndef IP_ADDRESS_TEXT_VALIDATOR_DEFINES_SVH
`define IP_ADDRESS_TEXT_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define IPV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define IPV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ipv_pkg.sv
// Types, constants and codes shared by the address text validator modules.
package ipv_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [8:0] V4_MAX_VALUE  = 9'd255;
  localparam logic [8:0] V4_SAT_VALUE  = 9'd256;
  localparam logic [1:0] V4_MAX_DIGITS = 2'd3;
  localparam logic [1:0] V4_MAX_DOTS   = 2'd3;
  localparam logic [2:0] V6_MAX_COLONS = 3'd7;
  localparam logic [2:0] V6_MAX_DIGITS = 3'd4;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_V4   = 2'd1,
    VERDICT_V6   = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    CC_DEC,
    CC_HEX_ALPHA,
    CC_DOT,
    CC_COLON,
    CC_OTHER
  } char_class_e;

  // One classified character as it travels from the front to the checker.
  typedef struct packed {
    char_class_e cls;
    logic [3:0]  digit;
    logic        last;
  } token_t;

  // Handshake status the checker reports back to the top level.
  typedef struct packed {
    logic tok_pop;
    logic res_push;
  } chk_status_t;

endpackage

// File: hdl/ipv_classify.sv
// Front end: sorts each incoming character into a token class.
module ipv_classify (
  input  logic [7:0]      char_byte_i,
  input  logic            is_last_i,
  output ipv_pkg::token_t token_o
);
  import ipv_pkg::*;

  always_comb begin
    token_o.digit = char_byte_i[3:0];
    token_o.last  = is_last_i;
    if (char_byte_i >= 8'h30 && char_byte_i <= 8'h39) begin
      token_o.cls = CC_DEC;
    end else if ((char_byte_i >= 8'h61 && char_byte_i <= 8'h66) ||
                 (char_byte_i >= 8'h41 && char_byte_i <= 8'h46)) begin
      token_o.cls = CC_HEX_ALPHA;
    end else if (char_byte_i == CHAR_DOT) begin
      token_o.cls = CC_DOT;
    end else if (char_byte_i == CHAR_COLON) begin
      token_o.cls = CC_COLON;
    end else begin
      token_o.cls = CC_OTHER;
    end
  end

endmodule

// File: hdl/ipv_queue.sv
// Small flip-flop queue with push/pop handshakes on both sides.
module ipv_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = ipv_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hdl/ipv_checker.sv
// Back end: IPv4 and IPv6 syntax checkers and the end-of-string verdict.
module ipv_checker (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tok_valid_i,
  input  ipv_pkg::token_t        tok_i,
  input  logic                   res_full_i,
  output ipv_pkg::chk_status_t   status_o,
  output logic [1:0]             verdict_o
);
  import ipv_pkg::*;

  logic       v4_ok_q, v4_ok_d, v4_lz_q, v4_lz_d;
  logic [1:0] v4_dots_q, v4_dots_d, v4_digits_q, v4_digits_d;
  logic [8:0] v4_val_q, v4_val_d;
  logic       v6_ok_q, v6_ok_d;
  logic [2:0] v6_colons_q, v6_colons_d, v6_digits_q, v6_digits_d;
  logic [11:0] v4_sum;
  logic       advance;
  verdict_e   verdict;

  // A string's final character needs room in the result queue.
  assign advance           = tok_valid_i && (!tok_i.last || !res_full_i);
  assign status_o.tok_pop  = advance;
  assign status_o.res_push = advance && tok_i.last;
  assign v4_sum            = 12'(v4_val_q) * 12'd10 + 12'(tok_i.digit);

  always_comb begin
    v4_ok_d     = v4_ok_q;
    v4_lz_d     = v4_lz_q;
    v4_dots_d   = v4_dots_q;
    v4_digits_d = v4_digits_q;
    v4_val_d    = v4_val_q;
    case (tok_i.cls)
      CC_DEC: begin
        if (v4_digits_q >= V4_MAX_DIGITS || v4_lz_q) begin
          v4_ok_d = 1'b0;
        end else begin
          if (v4_digits_q == '0 && tok_i.digit == '0) begin
            v4_lz_d = 1'b1;
          end
          v4_val_d = (v4_sum > 12'(V4_SAT_VALUE)) ? V4_SAT_VALUE : v4_sum[8:0];
          if (v4_val_d > V4_MAX_VALUE) begin
            v4_ok_d = 1'b0;
          end
          v4_digits_d = v4_digits_q + 1'b1;
        end
      end
      CC_DOT: begin
        if (v4_digits_q == '0 || v4_dots_q >= V4_MAX_DOTS) begin
          v4_ok_d = 1'b0;
        end else begin
          v4_dots_d   = v4_dots_q + 1'b1;
          v4_val_d    = '0;
          v4_digits_d = '0;
          v4_lz_d     = 1'b0;
        end
      end
      default: begin
        v4_ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    v6_ok_d     = v6_ok_q;
    v6_colons_d = v6_colons_q;
    v6_digits_d = v6_digits_q;
    case (tok_i.cls) inside
      CC_DEC, CC_HEX_ALPHA: begin
        if (v6_digits_q >= V6_MAX_DIGITS) begin
          v6_ok_d = 1'b0;
        end else begin
          v6_digits_d = v6_digits_q + 1'b1;
        end
      end
      CC_COLON: begin
        if (v6_digits_q == '0 || v6_colons_q >= V6_MAX_COLONS) begin
          v6_ok_d = 1'b0;
        end else begin
          v6_colons_d = v6_colons_q + 1'b1;
          v6_digits_d = '0;
        end
      end
      default: begin
        v6_ok_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (v4_ok_d && v4_dots_d == V4_MAX_DOTS && v4_digits_d != '0) begin
      verdict = VERDICT_V4;
    end else if (v6_ok_d && v6_colons_d == V6_MAX_COLONS && v6_digits_d != '0) begin
      verdict = VERDICT_V6;
    end else begin
      verdict = VERDICT_NONE;
    end
  end
  assign verdict_o = verdict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_ok_q     <= 1'b1;
      v4_lz_q     <= 1'b0;
      v4_dots_q   <= '0;
      v4_digits_q <= '0;
      v4_val_q    <= '0;
      v6_ok_q     <= 1'b1;
      v6_colons_q <= '0;
      v6_digits_q <= '0;
    end else if (advance) begin
      if (tok_i.last) begin
        v4_ok_q     <= 1'b1;
        v4_lz_q     <= 1'b0;
        v4_dots_q   <= '0;
        v4_digits_q <= '0;
        v4_val_q    <= '0;
        v6_ok_q     <= 1'b1;
        v6_colons_q <= '0;
        v6_digits_q <= '0;
      end else begin
        v4_ok_q     <= v4_ok_d;
        v4_lz_q     <= v4_lz_d;
        v4_dots_q   <= v4_dots_d;
        v4_digits_q <= v4_digits_d;
        v4_val_q    <= v4_val_d;
        v6_ok_q     <= v6_ok_d;
        v6_colons_q <= v6_colons_d;
        v6_digits_q <= v6_digits_d;
      end
    end
  end

endmodule

// File: hdl/ip_address_text_validator.sv
// Top level of the IPv4/IPv6 address text validator.
//
// Usage: the address text enters one ASCII character per request on the
// input queue port (char_byte_i, is_last_i), taken on a clock edge where
// push is high and full is low. is_last_i marks the final character of a
// string. For each string exactly one verdict request appears on the result
// queue port: verdict_o is 0 for neither, 1 for valid IPv4, 2 for valid IPv6.
// It is valid while empty is low and leaves on an edge where pop is high.
//
// Throughput is one character per cycle while the result queue has room
// for each last character. A character goes through the classifier into a
// small token queue, which the checker drains one token per cycle under
// that condition; the checker's combinational verdict is written into the
// result queue, which drives the result port. If the receiver stops
// popping, the result queue fills; the checker then holds the next
// last-character token, the token queue fills, and full rises. Characters
// ahead of that token that are not last still flow while results wait.
// Reset empties both queues and returns both checkers to their start state,
// so the first character after reset begins a new string.
module ip_address_text_validator #(
  parameter int unsigned QueueDepth = ipv_pkg::QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte_i,
  input  logic       is_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] verdict_o
);
  import ipv_pkg::*;
  `include "ip_address_text_validator_defines.svh"

  token_t      tok_in, tok_out;
  logic [$bits(token_t)-1:0] tok_raw;
  logic        tok_empty, res_full;
  chk_status_t chk_status;
  logic [1:0]  chk_verdict;

  // Front end: classify the character on its way into the token queue.
  ipv_classify u_classify (
    .char_byte_i (char_byte_i),
    .is_last_i   (is_last_i),
    .token_o     (tok_in)
  );

  // Decoupling queue between the classifier and the checker.
  ipv_queue #(
    .Width ($bits(token_t)),
    .Depth (QueueDepth)
  ) u_tok_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (tok_in),
    .full_o  (full),
    .pop_i   (chk_status.tok_pop),
    .data_o  (tok_raw),
    .empty_o (tok_empty)
  );
  assign tok_out = token_t'(tok_raw);

  // Back end: both syntax checkers run on every token.
  ipv_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!tok_empty),
    .tok_i       (tok_out),
    .res_full_i  (res_full),
    .status_o    (chk_status),
    .verdict_o   (chk_verdict)
  );

  // Result queue: parts the checker from a stalling receiver.
  ipv_queue #(
    .Width (2),
    .Depth (QueueDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (chk_status.res_push),
    .data_i  (chk_verdict),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (verdict_o),
    .empty_o (empty)
  );

  // A verdict is written only when the result queue has room.
  `IPV_ASSERT_NOW(a_res_push_room, chk_status.res_push, !res_full, "verdict pushed into full queue")
  // The checker consumes tokens only when one is waiting.
  `IPV_ASSERT_NOW(a_tok_pop_valid, chk_status.tok_pop, !tok_empty, "token popped from empty queue")
  // Every consumed last character produces a verdict in the same cycle.
  `IPV_ASSERT_NOW(a_last_gives_verdict, chk_status.tok_pop && tok_out.last, chk_status.res_push, "last token without verdict")
  // The reserved verdict code never reaches the result port.
  `IPV_ASSERT_NOW(a_verdict_code, !empty, verdict_o != 2'd3, "illegal verdict code")

endmodule

// File: dv/ip_address_text_validator_tb.sv
// Self-checking testbench for the IPv4/IPv6 address text validator.
`timescale 1ns / 100ps

module ip_address_text_validator_tb;
  import ipv_pkg::*;

  localparam int unsigned RandomChars = 1540;
  localparam int unsigned QuietChars  = 300;
  localparam int unsigned PhaseChars  = 150;
  localparam int unsigned LongHold    = 200;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned MaxReports  = 10;

  localparam logic [7:0] CHAR_ZERO    = "0";
  localparam logic [7:0] CHAR_NINE    = "9";
  localparam logic [7:0] CHAR_LOWER_A = "a";
  localparam logic [7:0] CHAR_LOWER_F = "f";
  localparam logic [7:0] CHAR_UPPER_A = "A";
  localparam logic [7:0] CHAR_UPPER_F = "F";

  // Follows both address checkers character by character and keeps the
  // verdicts that the block still owes, oldest first.
  class verdict_predictor;
    bit         dotted_ok;
    logic [1:0] dots_seen;
    int unsigned dec_value;
    logic [1:0] dec_digits;
    bit         zero_led;
    bit         colon_ok;
    logic [2:0] colons_seen;
    logic [2:0] hex_digits;
    verdict_e   pending_verdicts[$];
    int unsigned fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      dotted_ok   = 1'b1;
      dots_seen   = '0;
      dec_value   = 0;
      dec_digits  = '0;
      zero_led    = 1'b0;
      colon_ok    = 1'b1;
      colons_seen = '0;
      hex_digits  = '0;
    endfunction

    function int unsigned pending();
      return pending_verdicts.size();
    endfunction

    function void dotted_step(logic [7:0] c);
      int unsigned digit;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        digit = c - CHAR_ZERO;
        if (dec_digits >= V4_MAX_DIGITS || zero_led) begin
          dotted_ok = 1'b0;
          return;
        end
        if (dec_digits == 0 && digit == 0) zero_led = 1'b1;
        dec_value = dec_value * 10 + digit;
        if (dec_value > V4_SAT_VALUE) dec_value = V4_SAT_VALUE;
        if (dec_value > V4_MAX_VALUE) dotted_ok = 1'b0;
        dec_digits++;
      end else if (c == CHAR_DOT) begin
        if (dec_digits == 0 || dots_seen >= V4_MAX_DOTS) begin
          dotted_ok = 1'b0;
          return;
        end
        dots_seen++;
        dec_value  = 0;
        dec_digits = '0;
        zero_led   = 1'b0;
      end else begin
        dotted_ok = 1'b0;
      end
    endfunction

    function void colon_step(logic [7:0] c);
      if ((c >= CHAR_ZERO && c <= CHAR_NINE) ||
          (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
          (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
        if (hex_digits >= V6_MAX_DIGITS) begin
          colon_ok = 1'b0;
          return;
        end
        hex_digits++;
      end else if (c == CHAR_COLON) begin
        if (hex_digits == 0 || colons_seen >= V6_MAX_COLONS) begin
          colon_ok = 1'b0;
          return;
        end
        colons_seen++;
        hex_digits = '0;
      end else begin
        colon_ok = 1'b0;
      end
    endfunction

    // Called for every accepted character request.
    function void take_char(logic [7:0] c, logic last);
      verdict_e v;
      dotted_step(c);
      colon_step(c);
      if (!last) return;
      v = VERDICT_NONE;
      if (dotted_ok && dots_seen == V4_MAX_DOTS && dec_digits != 0) begin
        v = VERDICT_V4;
      end else if (colon_ok && colons_seen == V6_MAX_COLONS && hex_digits != 0) begin
        v = VERDICT_V6;
      end
      pending_verdicts.push_back(v);
      restart();
    endfunction

    // Called for every accepted verdict request.
    function void check_verdict(logic [1:0] got);
      verdict_e want;
      if (pending_verdicts.size() == 0) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: verdict %0d arrived with none outstanding", $realtime, got);
        end
        return;
      end
      want = pending_verdicts.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= MaxReports) begin
          $display("%0t: verdict mismatch, expected %0d (%s), got %0d",
                   $realtime, want, want.name(), got);
        end
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       push        = 1'b0;
  logic [7:0] char_byte_i = '0;
  logic       is_last_i   = 1'b0;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [1:0] verdict_o;

  verdict_predictor predictor;

  // Knobs shared by the sender, the receiver and the stimulus sequence.
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  bit          long_hold = 1'b0;
  int unsigned chars_sent = 0;
  int unsigned cycle_count = 0;

  // Text of the string currently being built or sent.
  logic [7:0] text_q[$];

  ip_address_text_validator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_byte_i(char_byte_i),
    .is_last_i  (is_last_i),
    .empty      (empty),
    .pop        (pop),
    .verdict_o  (verdict_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Both handshakes are sampled at the rising edge. All inputs change only
  // through nonblocking assignments, so the values seen here are the ones
  // the block saw at that same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) predictor.take_char(char_byte_i, is_last_i);
      if (pop && !empty) predictor.check_verdict(verdict_o);
    end
  end

  // Receiver. A requested long hold keeps pop low for a fixed stretch so the
  // result queue and then the token queue fill up and full rises; otherwise
  // pop idles in short random bursts while recv_idle is set.
  initial begin
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        pop <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (recv_idle && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** ip_address_text_validator: FAILED **");
    $finish;
  end

  // Offers one character request and returns at the edge that takes it.
  // push stays high from one character to the next unless a gap is drawn.
  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12);
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    char_byte_i <= c;
    is_last_i   <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    chars_sent++;
  endtask

  // Sends text_q as one string; the last character carries the end flag.
  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  // Appends a decimal number without leading zeros.
  function automatic void add_number(int unsigned value);
    if (value >= 100) text_q.push_back(CHAR_ZERO + 8'(value / 100));
    if (value >= 10) text_q.push_back(CHAR_ZERO + 8'((value / 10) % 10));
    text_q.push_back(CHAR_ZERO + 8'(value % 10));
  endfunction

  function automatic logic [7:0] pick_hex_char();
    int unsigned n;
    n = $urandom_range(0, 21);
    if (n < 10) return CHAR_ZERO + 8'(n);
    if (n < 16) return CHAR_LOWER_A + 8'(n - 10);
    return CHAR_UPPER_A + 8'(n - 16);
  endfunction

  // Characters that stress the checkers: separators, digits, hex letters
  // and arbitrary bytes.
  function automatic logic [7:0] pick_noise_char();
    case ($urandom_range(0, 4))
      0:       return CHAR_DOT;
      1:       return CHAR_COLON;
      2:       return CHAR_ZERO + 8'($urandom_range(0, 9));
      3:       return pick_hex_char();
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed dotted text, sometimes with a wrong group count, an
  // empty group, a leading zero or a value past 255.
  function automatic void build_dotted();
    int unsigned groups;
    groups = 4;
    if ($urandom_range(0, 15) == 0) groups = $urandom_range(3, 5);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_q.push_back(CHAR_DOT);
      if ($urandom_range(0, 23) == 0) continue;
      if ($urandom_range(0, 19) == 0) text_q.push_back(CHAR_ZERO);
      case ($urandom_range(0, 9))
        0:          add_number(0);
        1, 2, 3:    add_number($urandom_range(0, 9));
        4, 5, 6:    add_number($urandom_range(10, 99));
        7, 8:       add_number($urandom_range(100, 255));
        default:    add_number($urandom_range(256, 999));
      endcase
    end
  endfunction

  // Mostly well-formed colon text, sometimes with a wrong group count, an
  // empty group or a five-digit group.
  function automatic void build_colon();
    int unsigned groups;
    int unsigned digits;
    groups = 8;
    if ($urandom_range(0, 15) == 0) groups = $urandom_range(7, 9);
    for (int g = 0; g < groups; g++) begin
      if (g != 0) text_q.push_back(CHAR_COLON);
      if ($urandom_range(0, 23) == 0) continue;
      digits = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(1, 4);
      repeat (digits) text_q.push_back(pick_hex_char());
    end
  endfunction

  function automatic void build_random_text();
    int unsigned kind;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      build_dotted();
    end else if (kind < 8) begin
      build_colon();
    end else begin
      repeat ($urandom_range(1, 10)) text_q.push_back(pick_noise_char());
    end
    // Occasionally corrupt one character of an otherwise valid string.
    if (kind < 8 && $urandom_range(0, 5) == 0) begin
      text_q[$urandom_range(0, text_q.size() - 1)] = pick_noise_char();
    end
  endfunction

  initial begin
    int unsigned random_end;
    int unsigned quiet_from;
    int unsigned next_phase;

    predictor = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: valid texts at the value and digit extremes, then
    // one string for each way a checker can fail.
    send_string("0.0.0.0");
    send_string("255.255.255.255");
    send_string("256.1.1.1");
    send_string("999.9.9.9");
    send_string("01.2.3.4");
    send_string("1234.1.1.1");
    send_string("1.2.3.4.5");
    send_string(".1.2.3");
    send_string("1..2.3");
    send_string("1.2.3.");
    send_string("1.2.3");
    send_string("1.2.3.4 ");
    send_string("1:2:3:4:5:6:7:8");
    send_string("ffff:FFFF:aBcD:0:9:e:F:1");
    send_string("12345:1:1:1:1:1:1:1");
    send_string("1:2:3:4:5:6:7:8:9");
    send_string("1::2:3:4:5:6:7");
    send_string("1:2:3:4:5:6:7:");
    send_string("g:1:1:1:1:1:1:1");
    send_string(".");
    send_string(":");
    // Byte extremes, each as a one-character string.
    text_q = '{8'h00};
    send_text();
    text_q = '{8'hFF};
    send_text();

    // Back pressure: the receiver stops for a long stretch while short
    // strings keep coming, so every verdict request queues up and the input
    // side has to stall.
    long_hold = 1'b1;
    repeat (40) begin
      text_q = '{pick_noise_char()};
      send_text();
    end

    // Random strings. Idling is switched per phase so that some stretches
    // run at full rate, and the final stretch has no idling at all.
    random_end = chars_sent + RandomChars;
    quiet_from = random_end - QuietChars;
    next_phase = chars_sent;
    while (chars_sent < random_end) begin
      if (chars_sent >= quiet_from) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
      end else if (chars_sent >= next_phase) begin
        next_phase = chars_sent + PhaseChars;
        send_idle  = ($urandom_range(0, 3) != 0);
        recv_idle  = ($urandom_range(0, 3) != 0);
      end
      build_random_text();
      send_text();
    end
    push <= 1'b0;

    // Let every outstanding verdict come out, then watch a little longer
    // for anything the block should not have produced.
    while (predictor.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (predictor.fail_count == 0 && predictor.pending() == 0) begin
      $display("** ip_address_text_validator: PASSED **");
    end else begin
      $display("** ip_address_text_validator: FAILED **");
    end
    $finish;
  end

endmodule
